// ----- rtl/core/odtt_pkg.sv -----
// ----------------------------------------------------------------------------
// One-shot delay task table: shared definitions
// Item, slot record and result types, opcodes and default sizes.
// ----------------------------------------------------------------------------
package odtt_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int FIRST_SLOT_DEF = 1;

    localparam int CHUNK_W     = 16;
    localparam int CHUNK_IDX_W = $clog2(CHUNK_W);

    localparam int SLOT_IDX_OUT_W = 4;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

    typedef enum logic {
        KIND_FIRE = 1'b0,
        KIND_ACK  = 1'b1
    } t_kind;

    typedef struct packed {
        t_op                op;
        logic        [31:0] delay_ticks;
        logic        [3:0]  handler_sel;
        logic        [7:0]  tag_word;
        logic signed [31:0] arg_first;
        logic signed [31:0] arg_second;
        logic        [31:0] context_word;
    } t_item;

    typedef struct packed {
        logic        [31:0] start_tick;
        logic        [31:0] delay_ticks;
        logic        [3:0]  handler_sel;
        logic        [7:0]  tag_word;
        logic signed [31:0] arg_first;
        logic signed [31:0] arg_second;
        logic        [31:0] context_word;
    } t_slot;

    typedef struct packed {
        t_kind                       kind;
        logic [SLOT_IDX_OUT_W-1:0]   slot_index;
        logic                        table_full;
        logic        [3:0]           fired_handler;
        logic        [7:0]           fired_tag;
        logic signed [31:0]          fired_arg_first;
        logic signed [31:0]          fired_arg_second;
        logic        [31:0]          fired_context;
    } t_result;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage

// ----- rtl/core/odtt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module odtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/odtt_front.sv -----
// ----------------------------------------------------------------------------
// One-shot delay task table: front end
// Takes command transfers, tags each item as tick or insert and holds it in
// a two-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module odtt_front
    import odtt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [31:0]        i_delay_ticks,
    input  logic [3:0]         i_handler_sel,
    input  logic [7:0]         i_tag_word,
    input  logic signed [31:0] i_arg_first,
    input  logic signed [31:0] i_arg_second,
    input  logic [31:0]        i_context_word,
    output t_queue_head        o_head,
    input  logic               i_pop
);

    t_item      r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       n_wptr;
    logic       n_rptr;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;
    t_item      new_item;

    assign busy = (r_cnt == 2'd2);
    assign push = start && !busy;
    assign pop  = i_pop && (r_cnt != 2'd0);

    always_comb begin
        new_item.op           = i_op ? OP_INSERT : OP_TICK;
        new_item.delay_ticks  = i_delay_ticks;
        new_item.handler_sel  = i_handler_sel;
        new_item.tag_word     = i_tag_word;
        new_item.arg_first    = i_arg_first;
        new_item.arg_second   = i_arg_second;
        new_item.context_word = i_context_word;
    end

    always_comb begin
        n_wptr = push ? ~r_wptr : r_wptr;
        n_rptr = pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= new_item;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rptr];

endmodule

// ----- rtl/core/odtt_back.sv -----
// ----------------------------------------------------------------------------
// One-shot delay task table: back end
// Runs queued items in order: searches the lowest free slot for an insert,
// or reads the slot under the scan pointer and checks its deadline on a tick.
// ----------------------------------------------------------------------------
module odtt_back
    import odtt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int FIRST_SLOT = FIRST_SLOT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int NCHUNK  = (SLOT_COUNT + CHUNK_W - 1) / CHUNK_W;
    localparam int CH_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int SLOT_W  = $bits(t_slot);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_DIFF,
        S_CMP
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    t_item                   r_item;
    logic [31:0]             r_tick;
    logic [IDX_W-1:0]        r_ptr;
    logic [SLOT_COUNT-1:0]   r_valid;
    logic [CH_W-1:0]         r_chunk;
    logic [32:0]             r_sub;
    logic [31:0]             r_diff;
    logic                    r_res_valid;
    t_result                 r_res;
    logic                    n_res_valid;
    t_result                 n_res;

    logic [NCHUNK*CHUNK_W-1:0] occ;
    logic [CHUNK_W-1:0]        chunk_bits;
    logic [CHUNK_IDX_W-1:0]    enc;
    logic                      found;
    logic [CH_W+CHUNK_IDX_W-1:0] slot_wide;
    logic [IDX_W-1:0]          free_slot;
    logic [IDX_W+SLOT_IDX_OUT_W-1:0] free_ext;
    logic [IDX_W+SLOT_IDX_OUT_W-1:0] ptr_ext;
    logic [IDX_W-1:0]          ptr_next;
    logic                      last_chunk;
    logic                      fire;

    logic              ram_we;
    logic              ram_re;
    t_slot             wr_slot;
    t_slot             rd_slot;
    logic [SLOT_W-1:0] rd_bits;

    for (genvar g = 0; g < NCHUNK * CHUNK_W; g++) begin : g_occ
        if (g >= SLOT_COUNT || g < FIRST_SLOT) begin : g_fixed
            assign occ[g] = 1'b1;
        end else begin : g_slot
            assign occ[g] = r_valid[g];
        end
    end

    assign chunk_bits = occ[r_chunk*CHUNK_W +: CHUNK_W];

    always_comb begin
        enc   = '0;
        found = 1'b0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            if (!chunk_bits[i]) begin
                enc   = CHUNK_IDX_W'(i);
                found = 1'b1;
            end
        end
    end

    assign slot_wide  = {r_chunk, enc};
    assign free_slot  = slot_wide[IDX_W-1:0];
    assign free_ext   = {{SLOT_IDX_OUT_W{1'b0}}, free_slot};
    assign ptr_ext    = {{SLOT_IDX_OUT_W{1'b0}}, r_ptr};
    assign ptr_next   = (r_ptr == IDX_W'(SLOT_COUNT - 1)) ? '0 : r_ptr + 1'b1;
    assign last_chunk = (r_chunk == CH_W'(NCHUNK - 1));
    assign fire       = (r_diff >= rd_slot.delay_ticks);

    always_comb begin
        wr_slot.start_tick   = r_tick;
        wr_slot.delay_ticks  = r_item.delay_ticks;
        wr_slot.handler_sel  = r_item.handler_sel;
        wr_slot.tag_word     = r_item.tag_word;
        wr_slot.arg_first    = r_item.arg_first;
        wr_slot.arg_second   = r_item.arg_second;
        wr_slot.context_word = r_item.context_word;
    end

    assign rd_slot = t_slot'(rd_bits);
    assign ram_we  = (r_state == S_SEARCH) && found;
    assign ram_re  = (r_state == S_IDLE) && i_head.valid
                     && (i_head.item.op == OP_TICK) && r_valid[r_ptr];
    assign o_pop   = (r_state == S_IDLE) && i_head.valid;

    odtt_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(free_slot),
        .i_wdata(wr_slot),
        .i_re   (ram_re),
        .i_raddr(r_ptr),
        .o_rdata(rd_bits)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.item.op == OP_INSERT) begin
                        n_state = S_SEARCH;
                    end else if (r_valid[r_ptr]) begin
                        n_state = S_READ;
                    end
                end
            end
            S_SEARCH: begin
                if (found || last_chunk) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: n_state = S_DIFF;
            S_DIFF: n_state = S_CMP;
            S_CMP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_res_valid = 1'b0;
        n_res       = r_res;
        if (r_state == S_SEARCH && found) begin
            n_res_valid = 1'b1;
            n_res = '{kind: KIND_ACK, slot_index: free_ext[SLOT_IDX_OUT_W-1:0],
                      table_full: 1'b0, fired_handler: '0, fired_tag: '0,
                      fired_arg_first: '0, fired_arg_second: '0, fired_context: '0};
        end else if (r_state == S_SEARCH && last_chunk) begin
            n_res_valid = 1'b1;
            n_res = '{kind: KIND_ACK, slot_index: '0, table_full: 1'b1,
                      fired_handler: '0, fired_tag: '0, fired_arg_first: '0,
                      fired_arg_second: '0, fired_context: '0};
        end else if (r_state == S_CMP && fire) begin
            n_res_valid = 1'b1;
            n_res = '{kind: KIND_FIRE, slot_index: ptr_ext[SLOT_IDX_OUT_W-1:0],
                      table_full: 1'b0, fired_handler: rd_slot.handler_sel,
                      fired_tag: rd_slot.tag_word, fired_arg_first: rd_slot.arg_first,
                      fired_arg_second: rd_slot.arg_second,
                      fired_context: rd_slot.context_word};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_ptr       <= '0;
            r_valid     <= '0;
            r_chunk     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_res       <= n_res;
            unique case (r_state)
                S_IDLE: begin
                    r_chunk <= '0;
                    if (i_head.valid) begin
                        r_item <= i_head.item;
                        if (i_head.item.op == OP_TICK && !r_valid[r_ptr]) begin
                            r_ptr  <= ptr_next;
                            r_tick <= r_tick + 32'd1;
                        end
                    end
                end
                S_SEARCH: begin
                    if (found) begin
                        r_valid[free_slot] <= 1'b1;
                    end else if (!last_chunk) begin
                        r_chunk <= r_chunk + 1'b1;
                    end
                end
                S_READ: begin
                    r_sub <= {1'b0, r_tick} - {1'b0, rd_slot.start_tick};
                end
                S_DIFF: begin
                    r_diff <= r_sub[32] ? (~r_sub[31:0] + 32'd1) : r_sub[31:0];
                end
                S_CMP: begin
                    if (fire) begin
                        r_valid[r_ptr] <= 1'b0;
                    end
                    r_ptr  <= ptr_next;
                    r_tick <= r_tick + 32'd1;
                end
                default: ;
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- rtl/core/oneshot_delay_task_table_core.sv -----
// ----------------------------------------------------------------------------
// One-shot delay task table
// Holds up to SLOT_COUNT - FIRST_SLOT pending one-shot tasks and fires them on ticks.
//
// Commands: drive the item fields and raise start; the item transfers at a
// rising edge where start is high and busy is low. op 1 inserts a task, op 0
// advances time by one tick and checks the slot under the scan pointer.
// Results: o_valid marks each result for exactly one cycle and the result
// transfers at the edge that ends that cycle; the receiver cannot stall, so
// results are never held back. An insert always answers (slot or full flag);
// a tick answers only when the scanned task is due.
// Back end work per item: an insert searches the occupancy in 16-slot chunks,
// lowest first, until a free slot turns up or the last chunk is searched; a
// tick on an empty slot only advances the pointer and the tick, and a tick on
// an occupied slot reads the slot RAM once and passes S_READ, S_DIFF and S_CMP.
// The back end takes the next queued item only after it has returned to idle,
// so items already queued add their own back-end time.
// A two-entry queue buffers commands; busy is high while it is full.
// Reset empties the queue and the table and zeroes the tick and pointer.
// ----------------------------------------------------------------------------
module oneshot_delay_task_table_core
    import odtt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int FIRST_SLOT = FIRST_SLOT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [31:0]        i_delay_ticks,
    input  logic [3:0]         i_handler_sel,
    input  logic [7:0]         i_tag_word,
    input  logic signed [31:0] i_arg_first,
    input  logic signed [31:0] i_arg_second,
    input  logic [31:0]        i_context_word,
    output logic               o_valid,
    output logic               o_kind,
    output logic [3:0]         o_slot_index,
    output logic               o_table_full,
    output logic [3:0]         o_fired_handler,
    output logic [7:0]         o_fired_tag,
    output logic signed [31:0] o_fired_arg_first,
    output logic signed [31:0] o_fired_arg_second,
    output logic [31:0]        o_fired_context
);

    t_queue_head head;
    logic        pop;
    t_result     res;

    odtt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_delay_ticks (i_delay_ticks),
        .i_handler_sel (i_handler_sel),
        .i_tag_word    (i_tag_word),
        .i_arg_first   (i_arg_first),
        .i_arg_second  (i_arg_second),
        .i_context_word(i_context_word),
        .o_head        (head),
        .i_pop         (pop)
    );

    odtt_back #(
        .SLOT_COUNT(SLOT_COUNT),
        .FIRST_SLOT(FIRST_SLOT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_res_valid(o_valid),
        .o_res      (res)
    );

    assign o_kind             = res.kind;
    assign o_slot_index       = res.slot_index;
    assign o_table_full       = res.table_full;
    assign o_fired_handler    = res.fired_handler;
    assign o_fired_tag        = res.fired_tag;
    assign o_fired_arg_first  = res.fired_arg_first;
    assign o_fired_arg_second = res.fired_arg_second;
    assign o_fired_context    = res.fired_context;

endmodule

// ----- rtl/core/odtt_checker.sv -----
// ----------------------------------------------------------------------------
// One-shot delay task table: port checker
// Watches the top-level ports for result framing, acknowledge contents and the full flag on fired results.
// ----------------------------------------------------------------------------
module odtt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        o_kind,
    input logic [3:0]  o_slot_index,
    input logic        o_table_full,
    input logic [3:0]  o_fired_handler,
    input logic [7:0]  o_fired_tag,
    input logic [31:0] o_fired_arg_first,
    input logic [31:0] o_fired_arg_second,
    input logic [31:0] o_fired_context
);

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("Two result transfers in consecutive cycles.");

    a_full_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_kind && o_slot_index == 4'd0))
        else $error("Full flag on a result that is not an empty acknowledge.");

    a_ack_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (o_fired_handler == 4'd0 && o_fired_tag == 8'd0
            && o_fired_arg_first == 32'd0 && o_fired_arg_second == 32'd0
            && o_fired_context == 32'd0))
        else $error("Insert acknowledge carries task payload.");

    a_fire_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> !o_table_full)
        else $error("Fired task result carries the full flag.");

endmodule

bind oneshot_delay_task_table_core odtt_checker u_odtt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .o_kind            (o_kind),
    .o_slot_index      (o_slot_index),
    .o_table_full      (o_table_full),
    .o_fired_handler   (o_fired_handler),
    .o_fired_tag       (o_fired_tag),
    .o_fired_arg_first (o_fired_arg_first),
    .o_fired_arg_second(o_fired_arg_second),
    .o_fired_context   (o_fired_context)
);

// ----- dv/oneshot_delay_task_table_core_test.sv -----
// ----------------------------------------------------------------------------
// One-shot delay task table: block-level test
// Drives insert and tick commands through the start/busy handshake, predicts
// every acknowledge and every fired task in a scoreboard of its own, and
// compares each strobed result field by field, in order, as it transfers.
// ----------------------------------------------------------------------------
module oneshot_delay_task_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import odtt_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int FIRST       = FIRST_SLOT_DEF;
    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_op;
    logic [31:0]        i_delay_ticks;
    logic [3:0]         i_handler_sel;
    logic [7:0]         i_tag_word;
    logic signed [31:0] i_arg_first;
    logic signed [31:0] i_arg_second;
    logic [31:0]        i_context_word;
    logic               o_valid;
    logic               o_kind;
    logic [3:0]         o_slot_index;
    logic               o_table_full;
    logic [3:0]         o_fired_handler;
    logic [7:0]         o_fired_tag;
    logic signed [31:0] o_fired_arg_first;
    logic signed [31:0] o_fired_arg_second;
    logic [31:0]        o_fired_context;

    logic [31:0] tick_now;
    int          scan_at;
    bit          slot_held [SLOTS];
    t_slot       slot_rec  [SLOTS];
    t_result     awaited_answers [$];
    int          full_answers;
    int          mismatch_count;
    int          cycle_count;
    bit          idle_ok;

    oneshot_delay_task_table_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_op               (i_op),
        .i_delay_ticks      (i_delay_ticks),
        .i_handler_sel      (i_handler_sel),
        .i_tag_word         (i_tag_word),
        .i_arg_first        (i_arg_first),
        .i_arg_second       (i_arg_second),
        .i_context_word     (i_context_word),
        .o_valid            (o_valid),
        .o_kind             (o_kind),
        .o_slot_index       (o_slot_index),
        .o_table_full       (o_table_full),
        .o_fired_handler    (o_fired_handler),
        .o_fired_tag        (o_fired_tag),
        .o_fired_arg_first  (o_fired_arg_first),
        .o_fired_arg_second (o_fired_arg_second),
        .o_fired_context    (o_fired_context)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void table_step(input t_item it);
        t_result     ans;
        int          s;
        logic [31:0] span;
        ans = '0;
        if (it.op == OP_INSERT) begin
            ans.kind = KIND_ACK;
            s = FIRST;
            while (s < SLOTS && slot_held[s]) s++;
            if (s == SLOTS) begin
                ans.table_full = 1'b1;
                full_answers++;
            end else begin
                slot_held[s] = 1'b1;
                slot_rec[s] = '{start_tick:   tick_now,
                                delay_ticks:  it.delay_ticks,
                                handler_sel:  it.handler_sel,
                                tag_word:     it.tag_word,
                                arg_first:    it.arg_first,
                                arg_second:   it.arg_second,
                                context_word: it.context_word};
                ans.slot_index = s[3:0];
            end
            awaited_answers.push_back(ans);
        end else begin
            if (slot_held[scan_at]) begin
                span = (tick_now > slot_rec[scan_at].start_tick)
                     ? tick_now - slot_rec[scan_at].start_tick
                     : slot_rec[scan_at].start_tick - tick_now;
                if (span >= slot_rec[scan_at].delay_ticks) begin
                    ans.kind             = KIND_FIRE;
                    ans.slot_index       = scan_at[3:0];
                    ans.fired_handler    = slot_rec[scan_at].handler_sel;
                    ans.fired_tag        = slot_rec[scan_at].tag_word;
                    ans.fired_arg_first  = slot_rec[scan_at].arg_first;
                    ans.fired_arg_second = slot_rec[scan_at].arg_second;
                    ans.fired_context    = slot_rec[scan_at].context_word;
                    slot_held[scan_at]   = 1'b0;
                    awaited_answers.push_back(ans);
                end
            end
            scan_at  = (scan_at == SLOTS - 1) ? 0 : scan_at + 1;
            tick_now = tick_now + 32'd1;
        end
    endfunction

    function automatic int tasks_waiting();
        int n;
        n = 0;
        for (int s = 0; s < SLOTS; s++) n += slot_held[s];
        return n;
    endfunction

    function automatic string answer_text(input t_result r);
        return {$sformatf("kind=%0d slot=%0d full=%0d handler=%0d tag=%02h ",
                          r.kind, r.slot_index, r.table_full, r.fired_handler,
                          r.fired_tag),
                $sformatf("a1=%08h a2=%08h ctx=%08h",
                          r.fired_arg_first, r.fired_arg_second, r.fired_context)};
    endfunction

    function automatic t_item make_item(input t_op op, input logic [31:0] delay);
        t_item it;
        it.op           = op;
        it.delay_ticks  = delay;
        it.handler_sel  = 4'($urandom_range(0, 15));
        it.tag_word     = 8'($urandom_range(0, 255));
        it.arg_first    = $urandom;
        it.arg_second   = $urandom;
        it.context_word = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 15);
            5, 6, 7:       return $urandom_range(16, 120);
            8:             return $urandom_range(121, 300);
            default:       return 32'd0;
        endcase
    endfunction

    // The start line stays high from one transfer to the next unless an idle
    // burst comes in between.
    task automatic send_item(input t_item it);
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_op           <= it.op;
        i_delay_ticks  <= it.delay_ticks;
        i_handler_sel  <= it.handler_sel;
        i_tag_word     <= it.tag_word;
        i_arg_first    <= it.arg_first;
        i_arg_second   <= it.arg_second;
        i_context_word <= it.context_word;
        do @(posedge i_clk); while (busy !== 1'b0);
        table_step(it);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid !== 1'b0) begin
            got.kind             = t_kind'(o_kind);
            got.slot_index       = o_slot_index;
            got.table_full       = o_table_full;
            got.fired_handler    = o_fired_handler;
            got.fired_tag        = o_fired_tag;
            got.fired_arg_first  = o_fired_arg_first;
            got.fired_arg_second = o_fired_arg_second;
            got.fired_context    = o_fired_context;
            if (awaited_answers.size() == 0) begin
                if (mismatch_count < 10)
                    $display("Result transfer with nothing pending: %s", answer_text(got));
                mismatch_count++;
            end else begin
                want = awaited_answers.pop_front();
                if (o_valid !== 1'b1
                        || got.kind !== want.kind
                        || got.slot_index !== want.slot_index
                        || got.table_full !== want.table_full
                        || got.fired_handler !== want.fired_handler
                        || got.fired_tag !== want.fired_tag
                        || got.fired_arg_first !== want.fired_arg_first
                        || got.fired_arg_second !== want.fired_arg_second
                        || got.fired_context !== want.fired_context) begin
                    if (mismatch_count < 10) begin
                        $display("Result mismatch, expected: %s", answer_text(want));
                        $display("                 actual:   %s", answer_text(got));
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_empty_ticks();
        repeat (2) send_item(make_item(OP_TICK, $urandom));
    endtask

    task automatic test_field_extremes();
        t_item it;
        it    = '0;
        it.op = OP_INSERT;
        send_item(it);
        it = '{op: OP_INSERT, delay_ticks: 32'd0, handler_sel: 4'hF, tag_word: 8'hFF,
               arg_first: 32'sh7FFF_FFFF, arg_second: 32'sh8000_0000,
               context_word: 32'hFFFF_FFFF};
        send_item(it);
        it.delay_ticks  = 32'd3;
        it.handler_sel  = 4'h6;
        it.tag_word     = 8'h5A;
        it.arg_first    = 32'sh8000_0000;
        it.arg_second   = 32'sh7FFF_FFFF;
        it.context_word = 32'h0000_0001;
        send_item(it);
        repeat (16) send_item(make_item(OP_TICK, $urandom));
        // A task with the largest delay never falls due and keeps its slot.
        it = '1;
        send_item(it);
    endtask

    task automatic test_table_full();
        int seen;
        seen = full_answers;
        while (full_answers < seen + 2)
            send_item(make_item(OP_INSERT, $urandom_range(0, 63)));
        while (tasks_waiting() > 1)
            send_item(make_item(OP_TICK, $urandom));
    endtask

    task automatic run_mix_block(input int pct);
        repeat (50) begin
            if ($urandom_range(1, 100) <= pct)
                send_item(make_item(OP_INSERT, pick_delay()));
            else
                send_item(make_item(OP_TICK, $urandom));
        end
    endtask

    function automatic int pick_insert_share();
        case ($urandom_range(0, 3))
            0:       return 20;
            1:       return 40;
            2:       return 55;
            default: return 75;
        endcase
    endfunction

    task automatic test_random_mix();
        repeat (20) begin
            idle_ok = ($urandom_range(0, 3) != 0);
            run_mix_block(pick_insert_share());
        end
    endtask

    task automatic test_steady_stream();
        idle_ok = 1'b0;
        repeat (8) run_mix_block(pick_insert_share());
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_op           <= OP_TICK;
        i_delay_ticks  <= '0;
        i_handler_sel  <= '0;
        i_tag_word     <= '0;
        i_arg_first    <= '0;
        i_arg_second   <= '0;
        i_context_word <= '0;
        tick_now       = '0;
        scan_at        = 0;
        full_answers   = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        idle_ok        = 1'b1;
        for (int s = 0; s < SLOTS; s++) slot_held[s] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_ticks();
        test_field_extremes();
        test_table_full();
        test_random_mix();
        test_steady_stream();

        start <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- oneshot_delay_task_table_core.f -----
rtl/core/odtt_pkg.sv
rtl/core/odtt_ram.sv
rtl/core/odtt_front.sv
rtl/core/odtt_back.sv
rtl/core/oneshot_delay_task_table_core.sv
rtl/core/odtt_checker.sv
dv/oneshot_delay_task_table_core_test.sv
